// ===== src/ulm_pkg.sv =====
// Shared widths and the Latin Extended lowercase ROM of the lowercase mapper.
package ulm_pkg;

   localparam int CP_W = 21;
   localparam int ROM_W = 10;

   localparam logic [ROM_W-1:0] ROM_LO = 10'h100;
   localparam logic [ROM_W-1:0] ROM_HI = 10'h217;

   typedef logic [CP_W-1:0] cp_type;
   typedef logic [ROM_W-1:0] rom_cp_type;

   // Lowercase of a code point in 0x0100-0x0217; other inputs return unchanged.
   function automatic rom_cp_type rom_lower(input rom_cp_type c);
      rom_cp_type r;
      logic even;
      even = ~c[0];
      r = c;
      case (c)
         10'h130: r = 10'h069;
         10'h178: r = 10'h0FF;
         10'h181: r = 10'h253;
         10'h182: r = 10'h183;
         10'h184: r = 10'h185;
         10'h186: r = 10'h254;
         10'h187: r = 10'h188;
         10'h18A: r = 10'h257;
         10'h18B: r = 10'h18C;
         10'h18E: r = 10'h258;
         10'h18F: r = 10'h259;
         10'h190: r = 10'h25B;
         10'h191: r = 10'h192;
         10'h193: r = 10'h260;
         10'h194: r = 10'h263;
         10'h196: r = 10'h269;
         10'h197: r = 10'h268;
         10'h198: r = 10'h199;
         10'h19C: r = 10'h26F;
         10'h19D: r = 10'h272;
         10'h19F: r = 10'h275;
         10'h1A7: r = 10'h1A8;
         10'h1A9: r = 10'h283;
         10'h1AC: r = 10'h1AD;
         10'h1AE: r = 10'h288;
         10'h1AF: r = 10'h1B0;
         10'h1B1: r = 10'h28A;
         10'h1B2: r = 10'h28B;
         10'h1B3: r = 10'h1B4;
         10'h1B5: r = 10'h1B6;
         10'h1B7: r = 10'h292;
         10'h1B8: r = 10'h1B9;
         10'h1BC: r = 10'h1BD;
         10'h1C4: r = 10'h1C6;
         10'h1C5: r = 10'h1C6;
         10'h1C7: r = 10'h1C9;
         10'h1C8: r = 10'h1C9;
         10'h1CA: r = 10'h1CC;
         10'h1CB: r = 10'h1CC;
         10'h1F1: r = 10'h1F3;
         10'h1F4: r = 10'h1F5;
         default: begin
            // pair runs: the capital of each pair sits at the given parity
            if ((c >= 10'h100 && c <= 10'h136 && even) ||
                (c >= 10'h139 && c <= 10'h147 && !even) ||
                (c >= 10'h14A && c <= 10'h176 && even) ||
                (c >= 10'h179 && c <= 10'h17D && !even) ||
                (c >= 10'h1A0 && c <= 10'h1A4 && even) ||
                (c >= 10'h1CD && c <= 10'h1ED && !even) ||
                (c >= 10'h1FA && c <= 10'h216 && even)) begin
               r = c + 10'd1;
            end
         end
      endcase
      return r;
   endfunction

endpackage

// ===== src/ulm_req_if.sv =====
// Request channel: one code point per transfer.
interface ulm_req_if;
   logic             valid;
   logic             ready;
   ulm_pkg::cp_type  code_point;

   modport source (output valid, output code_point, input ready);
   modport sink (input valid, input code_point, output ready);
endinterface

// ===== src/ulm_rsp_if.sv =====
// Response channel: one lowercase code point per transfer.
interface ulm_rsp_if;
   logic             valid;
   logic             ready;
   ulm_pkg::cp_type  lower_code_point;

   modport source (output valid, output lower_code_point, input ready);
   modport sink (input valid, input lower_code_point, output ready);
endinterface

// ===== src/unicode_lowercase_map_top.sv =====
// Top level of the simple lowercase mapper: input register, mapping, output register.
//
// Usage:
//  req carries one Unicode code point per request (valid/ready, taken when both
//  are high); rsp returns its simple lowercase form, or the code point unchanged
//  when no mapping applies. Values above 0x10FFFF pass unchanged.
//  Path: an accepted request is captured in the input register at the accepting
//  edge, mapped combinationally, and loaded into the output register, which
//  drives rsp.valid; the response then holds there until it is taken.
//  Throughput: one request per cycle while rsp.ready is high, set by the two-stage
//  register pipeline; each request gives exactly one response, in order.
//  Stall: while rsp.ready is low the response holds in the output register; the
//  input register still fills, so up to two requests are held before req.ready
//  drops. req.ready depends combinationally on rsp.ready.
//  Reset: synchronous, active high; clears both stage valids, so nothing is
//  presented on rsp and req.ready is high in the first cycle after reset.
module unicode_lowercase_map_top (
   input  logic           clock,
   input  logic           reset,
   ulm_req_if.sink        req,
   ulm_rsp_if.source      rsp
);

   logic            s1_valid_ff, s1_valid_in;
   ulm_pkg::cp_type s1_cp_ff;
   logic            out_valid_ff, out_valid_in;
   ulm_pkg::cp_type out_cp_ff;
   ulm_pkg::cp_type map_out;
   logic            out_load;
   logic            s1_load;

   // advance the mapped value when the output register is empty or draining
   assign out_load = !out_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || out_load;
   assign s1_load = req.valid && req.ready;

   assign s1_valid_in = s1_load || (s1_valid_ff && !out_load);
   assign out_valid_in = out_load ? s1_valid_ff : out_valid_ff;

   ulm_map u_map (
      .cp       (s1_cp_ff),
      .lower_cp (map_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) s1_cp_ff <= req.code_point;
      if (out_load && s1_valid_ff) out_cp_ff <= map_out;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.lower_code_point = out_cp_ff;

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_valid_ff) |=> out_valid_ff)
      else $error("input stage did not advance into empty output register");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp.ready) |-> !req.ready)
      else $error("request taken while both stages are full and stalled");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (!rsp.valid && !s1_valid_ff))
      else $error("pipeline not empty after reset");

   a_map_loaded: assert property (@(posedge clock) disable iff (reset)
      $past(s1_valid_ff && out_load && !reset) |-> (out_cp_ff == $past(map_out)))
      else $error("output register does not hold the mapped code point");

endmodule

// ===== src/ulm_map.sv =====
// Combinational simple lowercase mapping of one code point.
module ulm_map (
   input  ulm_pkg::cp_type cp,
   output ulm_pkg::cp_type lower_cp
);

   logic [12:0] page;
   ulm_pkg::rom_cp_type rom_out;
   ulm_pkg::cp_type c;
   ulm_pkg::cp_type odd_up;

   assign c = cp;
   assign page = c[20:8];
   assign odd_up = c | 21'd1;
   assign rom_out = ulm_pkg::rom_lower(c[ulm_pkg::ROM_W-1:0]);

   always_comb begin
      lower_cp = c;
      if (c >= 21'h41 && c <= 21'h5A) begin
         lower_cp = c + 21'h20;
      end else if (c >= 21'hC0 && c <= 21'hDE) begin
         // multiplication sign is not a letter
         if (c != 21'hD7) lower_cp = c + 21'h20;
      end else if (page >= 13'hFF) begin
         if (c >= 21'hFF21 && c <= 21'hFF3A) lower_cp = c + 21'h20;
      end else if (page >= 13'h20) begin
         if (c >= 21'h24B6 && c <= 21'h24CF) lower_cp = c + 21'h1A;
      end else if (page >= 13'h1E) begin
         if ((c >= 21'h1E00 && c <= 21'h1E94) || (c >= 21'h1EA0 && c <= 21'h1EF8)) begin
            lower_cp = odd_up;
         end else if ((c >= 21'h1F08 && c <= 21'h1F0F) || (c >= 21'h1F18 && c <= 21'h1F1D) ||
                      (c >= 21'h1F28 && c <= 21'h1F2F) || (c >= 21'h1F48 && c <= 21'h1F4D) ||
                      (c >= 21'h1F59 && c <= 21'h1F5F) || (c >= 21'h1F68 && c <= 21'h1F6F) ||
                      (c >= 21'h1F88 && c <= 21'h1F8F) || (c >= 21'h1F98 && c <= 21'h1F9F) ||
                      (c >= 21'h1FA8 && c <= 21'h1FAF) || (c >= 21'h1FB8 && c <= 21'h1FB9) ||
                      (c >= 21'h1FD8 && c <= 21'h1FD9) || (c >= 21'h1FE8 && c <= 21'h1FE9)) begin
            lower_cp = c - 21'd8;
         end
      end else if (page >= 13'h10) begin
         if (c >= 21'h10A0 && c <= 21'h10C5) lower_cp = c + 21'h30;
      end else if (page >= 13'h06) begin
         lower_cp = c;
      end else if (page >= 13'h04) begin
         if (c >= 21'h401 && c <= 21'h40F) begin
            lower_cp = c + 21'h50;
         end else if (c >= 21'h410 && c <= 21'h42F) begin
            lower_cp = c + 21'h20;
         end else if ((c >= 21'h460 && c <= 21'h480) || (c >= 21'h490 && c <= 21'h4BE)) begin
            lower_cp = odd_up;
         end else if (c >= 21'h4C1 && c <= 21'h4F8) begin
            if (c != 21'h4C5 && c != 21'h4C9 && c != 21'h4CD && c != 21'h4CF) begin
               lower_cp = odd_up;
            end
         end else if (c >= 21'h531 && c <= 21'h556) begin
            lower_cp = c + 21'h30;
         end
      end else if (page == 13'h03) begin
         case (c)
            21'h386: lower_cp = 21'h3AC;
            21'h388: lower_cp = 21'h3AD;
            21'h389: lower_cp = 21'h3AE;
            21'h38A: lower_cp = 21'h3AF;
            21'h38C: lower_cp = 21'h3CC;
            21'h38E: lower_cp = 21'h3CD;
            21'h38F: lower_cp = 21'h3CE;
            default: begin
               if (c >= 21'h391 && c <= 21'h3AB) begin
                  // hold the final sigma slot
                  if (c != 21'h3A2) lower_cp = c + 21'h20;
               end else if (c >= 21'h3E2 && c <= 21'h3EE) begin
                  lower_cp = odd_up;
               end
            end
         endcase
      end else begin
         lower_cp = {{(ulm_pkg::CP_W-ulm_pkg::ROM_W){1'b0}}, rom_out};
      end
   end

endmodule
